FILE: hw/rtl/pwt_pkg.sv
// Shared types and constants for the protobuf wire-format tokenizer.
package pwt_pkg;

    typedef enum logic [2:0] {
        TK_SCALAR   = 3'd0,
        TK_HEADER   = 3'd1,
        TK_PAYLOAD  = 3'd2,
        TK_TRUNC    = 3'd3,
        TK_BADWIRE  = 3'd4,
        TK_OVERLONG = 3'd5
    } t_token_kind;

    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_LENGTH  = 3'd2;
    localparam logic [2:0] WIRE_FIXED32 = 3'd5;

    localparam int FIELD_W = 29;
    localparam int WIRE_W  = 3;
    localparam int VALUE_W = 64;
    localparam int DATA_W  = FIELD_W + WIRE_W + VALUE_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    typedef struct packed {
        t_token_kind          kind;
        logic [FIELD_W-1:0]   field_number;
        logic [WIRE_W-1:0]    wire_kind;
        logic [VALUE_W-1:0]   field_value;
        logic                 message_end;
    } t_token;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

FILE: hw/rtl/pwt_front.sv
// Byte parser: decodes keys, varints, fixed values and payload runs into tokens.
module pwt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_byte_valid,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output logic           o_byte_ready,
    input  pwt_pkg::t_queue_status i_queue_status,
    output logic           o_push,
    output pwt_pkg::t_token o_token
);
    import pwt_pkg::*;

    typedef enum logic [2:0] {
        PH_KEY     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DROP    = 3'd5
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [3:0]         r_pos, n_pos;
    logic [FIELD_W-1:0] r_field, n_field;
    logic [WIRE_W-1:0]  r_wire, n_wire;
    logic [VALUE_W-1:0] r_rem, n_rem;

    logic               w_accept;
    logic [6:0]         w_sh7;
    logic [VALUE_W-1:0] w_acc_v;
    logic [VALUE_W-1:0] w_acc_f;
    logic [WIRE_W-1:0]  w_key_wire;
    logic [FIELD_W-1:0] w_key_field;
    logic               w_fail;
    logic               w_restart;

    assign o_byte_ready = !i_queue_status.full;
    assign w_accept     = i_byte_valid && o_byte_ready;

    // 7*pos for the varint group shift
    assign w_sh7       = {r_pos, 3'b000} - {3'b000, r_pos};
    assign w_acc_v     = r_acc | ({57'd0, i_byte[6:0]} << w_sh7);
    assign w_acc_f     = r_acc | ({56'd0, i_byte} << {r_pos[2:0], 3'b000});
    assign w_key_wire  = w_acc_v[WIRE_W-1:0];
    assign w_key_field = w_acc_v[WIRE_W+FIELD_W-1:WIRE_W];

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_pos     = r_pos;
        n_field   = r_field;
        n_wire    = r_wire;
        n_rem     = r_rem;
        w_fail    = 1'b0;
        w_restart = 1'b0;
        o_push    = 1'b0;
        o_token.kind         = TK_SCALAR;
        o_token.field_number = r_field;
        o_token.wire_kind    = r_wire;
        o_token.field_value  = '0;
        o_token.message_end  = i_last;

        if (w_accept) begin
            case (r_phase)
                PH_KEY, PH_VARINT, PH_LENGTH: begin
                    if (r_pos > 4'd9) begin
                        w_fail       = 1'b1;
                        o_token.kind = TK_OVERLONG;
                    end else if (i_byte[7]) begin
                        if (r_pos == 4'd9) begin
                            w_fail       = 1'b1;
                            o_token.kind = TK_OVERLONG;
                        end else begin
                            n_acc = w_acc_v;
                            n_pos = r_pos + 4'd1;
                            if (i_last) begin
                                w_fail       = 1'b1;
                                o_token.kind = TK_TRUNC;
                            end
                        end
                    end else if (r_phase == PH_KEY) begin
                        o_token.field_number = w_key_field;
                        o_token.wire_kind    = w_key_wire;
                        if (w_key_wire != WIRE_VARINT && w_key_wire != WIRE_FIXED64 &&
                            w_key_wire != WIRE_LENGTH && w_key_wire != WIRE_FIXED32) begin
                            w_fail       = 1'b1;
                            o_token.kind = TK_BADWIRE;
                        end else if (i_last) begin
                            w_fail       = 1'b1;
                            o_token.kind = TK_TRUNC;
                        end else begin
                            n_field = w_key_field;
                            n_wire  = w_key_wire;
                            n_acc   = '0;
                            n_pos   = '0;
                            if (w_key_wire == WIRE_VARINT) begin
                                n_phase = PH_VARINT;
                            end else if (w_key_wire == WIRE_LENGTH) begin
                                n_phase = PH_LENGTH;
                            end else begin
                                n_phase = PH_FIXED;
                            end
                        end
                    end else if (r_phase == PH_VARINT) begin
                        o_push              = 1'b1;
                        o_token.kind        = TK_SCALAR;
                        o_token.field_value = w_acc_v;
                        w_restart           = 1'b1;
                    end else if (w_acc_v == '0) begin
                        // zero length closes the field at the header
                        o_push       = 1'b1;
                        o_token.kind = TK_HEADER;
                        w_restart    = 1'b1;
                    end else if (i_last) begin
                        w_fail       = 1'b1;
                        o_token.kind = TK_TRUNC;
                    end else begin
                        o_push              = 1'b1;
                        o_token.kind        = TK_HEADER;
                        o_token.field_value = w_acc_v;
                        n_rem               = w_acc_v;
                        n_acc               = '0;
                        n_pos               = '0;
                        n_phase             = PH_PAYLOAD;
                    end
                end
                PH_FIXED: begin
                    if ((r_wire == WIRE_FIXED64) ? (r_pos >= 4'd7) : (r_pos >= 4'd3)) begin
                        o_push              = 1'b1;
                        o_token.kind        = TK_SCALAR;
                        o_token.field_value = w_acc_f;
                        w_restart           = 1'b1;
                    end else begin
                        n_acc = w_acc_f;
                        n_pos = r_pos + 4'd1;
                        if (i_last) begin
                            w_fail       = 1'b1;
                            o_token.kind = TK_TRUNC;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (r_rem == 64'd1) begin
                        o_push              = 1'b1;
                        o_token.kind        = TK_PAYLOAD;
                        o_token.field_value = {56'd0, i_byte};
                        w_restart           = 1'b1;
                    end else if (i_last) begin
                        w_fail       = 1'b1;
                        o_token.kind = TK_TRUNC;
                    end else begin
                        o_push              = 1'b1;
                        o_token.kind        = TK_PAYLOAD;
                        o_token.field_value = {56'd0, i_byte};
                        n_rem               = r_rem - 64'd1;
                    end
                end
                default: begin
                    // drop until the end of the message
                    if (i_last) begin
                        w_restart = 1'b1;
                    end
                end
            endcase

            if (w_fail) begin
                o_push              = 1'b1;
                o_token.field_value = '0;
            end
            if (w_fail || w_restart) begin
                n_phase = (w_fail && !i_last) ? PH_DROP : PH_KEY;
                n_acc   = '0;
                n_pos   = '0;
                n_field = '0;
                n_wire  = '0;
                n_rem   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_KEY;
            r_acc   <= '0;
            r_pos   <= '0;
            r_field <= '0;
            r_wire  <= '0;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_field <= n_field;
            r_wire  <= n_wire;
            r_rem   <= n_rem;
        end
    end

endmodule

FILE: hw/rtl/pwt_queue.sv
// Small token queue between the parser and the output stage.
module pwt_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  pwt_pkg::t_token        i_token,
    input  logic                   i_pop,
    output pwt_pkg::t_token        o_head,
    output pwt_pkg::t_queue_status o_status
);
    import pwt_pkg::*;

    t_token              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                w_push;
    logic                w_pop;

    assign o_status.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: hw/rtl/pwt_back.sv
// Output register stage: pulls tokens from the queue and drives the result stream.
module pwt_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pwt_pkg::t_token        i_head,
    input  pwt_pkg::t_queue_status i_status,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output pwt_pkg::t_token        o_token
);
    import pwt_pkg::*;

    logic   r_valid, n_valid;
    t_token r_token;

    // refill when the register is empty or its request is being taken
    assign o_pop   = !i_status.empty && (!r_valid || i_ready);
    assign n_valid = o_pop || (r_valid && !i_ready);
    assign o_valid = r_valid;
    assign o_token = r_token;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_token <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

FILE: hw/rtl/protobuf_wire_tokenizer.sv
// Protobuf wire-format tokenizer: top level joining parser, token queue and output stage.
//
// Takes one message byte per cycle (tlast on the message's last byte) and emits one
// token per finished scalar field, length header, payload byte or error. The parser
// handles each byte in the cycle it is accepted, so the sustained rate is one byte per
// clock; s_axis_tready drops only while the four-entry token queue is full, which
// happens when the result side stalls. A token is written into the token queue at the edge
// that accepts its byte and moves on to the output register when the result side is free.
module protobuf_wire_tokenizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] in_byte
    input  logic          s_axis_tlast,   // last_byte
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [95:0]   m_axis_tdata,   // [28:0] field_number, [31:29] wire_kind,
                                          // [95:32] field_value
    output logic [2:0]    m_axis_tuser,   // [2:0] token_kind
    output logic          m_axis_tlast    // message_end
);
    import pwt_pkg::*;

    logic          w_push;
    t_token        w_push_token;
    t_token        w_head;
    t_queue_status w_status;
    logic          w_pop;
    t_token        w_out_token;

    pwt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (s_axis_tvalid),
        .i_byte         (s_axis_tdata),
        .i_last         (s_axis_tlast),
        .o_byte_ready   (s_axis_tready),
        .i_queue_status (w_status),
        .o_push         (w_push),
        .o_token        (w_push_token)
    );

    pwt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_token  (w_push_token),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    pwt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_token  (w_out_token)
    );

    assign m_axis_tdata = {w_out_token.field_value, w_out_token.wire_kind,
                           w_out_token.field_number};
    assign m_axis_tuser = w_out_token.kind;
    assign m_axis_tlast = w_out_token.message_end;

endmodule

FILE: sim/tb_protobuf_wire_tokenizer.sv
// Self-checking testbench for the protobuf wire-format tokenizer stream block.
`timescale 1ns / 100ps

module tb_protobuf_wire_tokenizer;
    import pwt_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int N_DIR       = 26;
    localparam int PHASE_BYTES = 115;
    localparam int DRAIN_CYCLES = 8;

    // Wire types that the block must reject
    localparam logic [2:0] WIRE_GROUP_START = 3'd3;
    localparam logic [2:0] WIRE_GROUP_END   = 3'd4;
    localparam logic [2:0] WIRE_RSVD6       = 3'd6;
    localparam logic [2:0] WIRE_RSVD7       = 3'd7;

    typedef enum logic [2:0] {
        ST_KEY     = 3'd0,
        ST_VARINT  = 3'd1,
        ST_FIXED   = 3'd2,
        ST_LENGTH  = 3'd3,
        ST_PAYLOAD = 3'd4,
        ST_DROP    = 3'd5
    } t_parse_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_token     tok;
    } t_dir_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [7:0]    s_axis_tdata = '0;   // [7:0] in_byte
    logic          s_axis_tlast = 1'b0; // last_byte
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [95:0]   m_axis_tdata;        // [28:0] field_number, [31:29] wire_kind,
                                        // [95:32] field_value
    logic [2:0]    m_axis_tuser;        // [2:0] token_kind
    logic          m_axis_tlast;        // message_end

    // Shadow parser state
    t_parse_state        prs_phase = ST_KEY;
    logic [63:0]         prs_acc = '0;
    logic [3:0]          prs_pos = '0;
    logic [FIELD_W-1:0]  prs_field = '0;
    logic [WIRE_W-1:0]   prs_wire = '0;
    logic [63:0]         prs_remaining = '0;

    t_token      pending_tokens[$];
    logic [7:0]  msg_bytes[$];
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          sent_bytes = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          src_idle_tab[4]  = '{0, 76, 0, 18};
    int          sink_stall_tab[4] = '{0, 0, 76, 18};

    localparam t_token NO_TOKEN = '0;

    t_dir_row dir_rows [N_DIR] = '{
        '{8'h08, 1'b0, 1'b0, NO_TOKEN},
        '{8'h00, 1'b1, 1'b1, '{TK_SCALAR, 29'd1, WIRE_VARINT, 64'd0, 1'b1}},
        // key cut short by the end of the message
        '{8'h80, 1'b1, 1'b1, '{TK_TRUNC, 29'd0, WIRE_VARINT, 64'd0, 1'b1}},
        '{8'h0B, 1'b1, 1'b1, '{TK_BADWIRE, 29'd1, WIRE_GROUP_START, 64'd0, 1'b1}},
        // key with no value
        '{8'h10, 1'b1, 1'b1, '{TK_TRUNC, 29'd2, WIRE_VARINT, 64'd0, 1'b1}},
        // zero-length field
        '{8'h1A, 1'b0, 1'b0, NO_TOKEN},
        '{8'h00, 1'b1, 1'b1, '{TK_HEADER, 29'd3, WIRE_LENGTH, 64'd0, 1'b1}},
        '{8'h12, 1'b0, 1'b0, NO_TOKEN},
        '{8'h02, 1'b0, 1'b0, NO_TOKEN},
        '{8'hAA, 1'b0, 1'b0, NO_TOKEN},
        '{8'h55, 1'b1, 1'b0, NO_TOKEN},
        '{8'h0D, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b1, 1'b1, '{TK_SCALAR, 29'd1, WIRE_FIXED32, 64'hFFFF_FFFF, 1'b1}},
        // key varint running past ten bytes
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF, 1'b1, 1'b1, '{TK_OVERLONG, 29'd0, WIRE_VARINT, 64'd0, 1'b1}}
    };

    protobuf_wire_tokenizer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void restart_parse();
        prs_phase     = ST_KEY;
        prs_acc       = '0;
        prs_pos       = '0;
        prs_field     = '0;
        prs_wire      = '0;
        prs_remaining = '0;
    endfunction

    function automatic void make_token(input t_token_kind kind, input logic [63:0] value,
                                       input logic last, output t_token tok);
        tok.kind         = kind;
        tok.field_number = prs_field;
        tok.wire_kind    = prs_wire;
        tok.field_value  = value;
        tok.message_end  = last;
    endfunction

    function automatic void parse_error(input t_token_kind kind, input logic last,
                                        output t_token tok);
        make_token(kind, 64'd0, last, tok);
        if (last) begin
            restart_parse();
        end else begin
            prs_phase = ST_DROP;
        end
    endfunction

    // Advance the shadow parser by one byte; return 1 when a token comes out.
    function automatic bit tokenize_byte(input logic [7:0] b, input logic last,
                                         output t_token tok);
        int need;
        tok = '0;
        case (prs_phase)
            ST_KEY, ST_VARINT, ST_LENGTH: begin
                if (prs_pos > 4'd9) begin
                    parse_error(TK_OVERLONG, last, tok);
                    return 1;
                end
                prs_acc |= 64'(b[6:0]) << (7 * prs_pos);
                if (b[7]) begin
                    if (prs_pos == 4'd9) begin
                        parse_error(TK_OVERLONG, last, tok);
                        return 1;
                    end
                    prs_pos++;
                    if (last) begin
                        parse_error(TK_TRUNC, last, tok);
                        return 1;
                    end
                    return 0;
                end
                if (prs_phase == ST_KEY) begin
                    prs_wire  = prs_acc[2:0];
                    prs_field = prs_acc[31:3];
                    prs_acc   = '0;
                    prs_pos   = '0;
                    if (prs_wire != WIRE_VARINT && prs_wire != WIRE_FIXED64 &&
                        prs_wire != WIRE_LENGTH && prs_wire != WIRE_FIXED32) begin
                        parse_error(TK_BADWIRE, last, tok);
                        return 1;
                    end
                    if (last) begin
                        parse_error(TK_TRUNC, last, tok);
                        return 1;
                    end
                    prs_phase = (prs_wire == WIRE_VARINT) ? ST_VARINT :
                                (prs_wire == WIRE_LENGTH) ? ST_LENGTH : ST_FIXED;
                    return 0;
                end
                if (prs_phase == ST_VARINT) begin
                    make_token(TK_SCALAR, prs_acc, last, tok);
                    restart_parse();
                    return 1;
                end
                if (prs_acc == 64'd0) begin
                    make_token(TK_HEADER, 64'd0, last, tok);
                    restart_parse();
                    return 1;
                end
                if (last) begin
                    parse_error(TK_TRUNC, last, tok);
                    return 1;
                end
                make_token(TK_HEADER, prs_acc, 1'b0, tok);
                prs_remaining = prs_acc;
                prs_acc       = '0;
                prs_pos       = '0;
                prs_phase     = ST_PAYLOAD;
                return 1;
            end
            ST_FIXED: begin
                need = (prs_wire == WIRE_FIXED64) ? 8 : 4;
                prs_acc |= 64'(b) << (8 * prs_pos[2:0]);
                if (int'(prs_pos) + 1 >= need) begin
                    make_token(TK_SCALAR, prs_acc, last, tok);
                    restart_parse();
                    return 1;
                end
                prs_pos++;
                if (last) begin
                    parse_error(TK_TRUNC, last, tok);
                    return 1;
                end
                return 0;
            end
            ST_PAYLOAD: begin
                prs_remaining--;
                if (prs_remaining == 64'd0) begin
                    make_token(TK_PAYLOAD, 64'(b), last, tok);
                    restart_parse();
                    return 1;
                end
                if (last) begin
                    parse_error(TK_TRUNC, last, tok);
                    return 1;
                end
                make_token(TK_PAYLOAD, 64'(b), 1'b0, tok);
                return 1;
            end
            default: begin
                if (last) restart_parse();
                return 0;
            end
        endcase
    endfunction

    function automatic int varint_bytes(input logic [63:0] v);
        int n;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 64'd0) n++;
        return n;
    endfunction

    function automatic void push_varint(input logic [63:0] v, input int pad);
        int n;
        n = varint_bytes(v) + pad;
        if (n > 10) n = 10;
        for (int i = 0; i < n; i++) begin
            msg_bytes.push_back({(i < n - 1), v[6:0]});
            v = v >> 7;
        end
    endfunction

    // Present one request, wait for its acceptance, then predict its token.
    task automatic apply_byte(input logic [7:0] b, input logic last, input logic typed,
                              input t_token typed_tok);
        t_token tok;
        bit     got;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_bytes++;
        got = tokenize_byte(b, last, tok);
        if (typed) begin
            pending_tokens.push_back(typed_tok);
        end else if (got) begin
            pending_tokens.push_back(tok);
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : check_tokens
        t_token want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_tokens.size() == 0) begin
                $error("token_kind: expected none, actual %0d", m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_tokens.pop_front();
                if (m_axis_tuser != want.kind) begin
                    $error("token_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[28:0] != want.field_number) begin
                    $error("field_number: expected %0d, actual %0d",
                           want.field_number, m_axis_tdata[28:0]);
                    mismatches++;
                end
                if (m_axis_tdata[31:29] != want.wire_kind) begin
                    $error("wire_kind: expected %0d, actual %0d",
                           want.wire_kind, m_axis_tdata[31:29]);
                    mismatches++;
                end
                if (m_axis_tdata[95:32] != want.field_value) begin
                    $error("field_value: expected %h, actual %h",
                           want.field_value, m_axis_tdata[95:32]);
                    mismatches++;
                end
                if (m_axis_tlast != want.message_end) begin
                    $error("message_end: expected %0d, actual %0d",
                           want.message_end, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("protobuf_wire_tokenizer regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int          r;
        int          nfields;
        int          len;
        int          cut;
        logic [2:0]  wire_sel;
        logic [28:0] fnum;
        logic [63:0] val;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            apply_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                       dir_rows[i].tok);
        end

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = src_idle_tab[ph];
            sink_stall_pct = sink_stall_tab[ph];
            sent_bytes     = 0;
            while (sent_bytes < PHASE_BYTES) begin
                msg_bytes.delete();
                nfields = $urandom_range(1, 4);
                repeat (nfields) begin
                    r = $urandom_range(2);
                    fnum = (r == 0) ? 29'($urandom_range(1, 15)) :
                           (r == 1) ? 29'($urandom_range(16, 4095)) : 29'($urandom());
                    r = $urandom_range(99);
                    if (r < 30) begin
                        wire_sel = WIRE_VARINT;
                    end else if (r < 45) begin
                        wire_sel = WIRE_FIXED32;
                    end else if (r < 60) begin
                        wire_sel = WIRE_FIXED64;
                    end else if (r < 85) begin
                        wire_sel = WIRE_LENGTH;
                    end else begin
                        case ($urandom_range(3))
                            0:       wire_sel = WIRE_GROUP_START;
                            1:       wire_sel = WIRE_GROUP_END;
                            2:       wire_sel = WIRE_RSVD6;
                            default: wire_sel = WIRE_RSVD7;
                        endcase
                    end
                    push_varint({32'd0, fnum, wire_sel}, ($urandom_range(9) == 0) ? 1 : 0);
                    if (wire_sel == WIRE_VARINT) begin
                        r = $urandom_range(99);
                        if (r < 8) begin
                            // ten bytes, upper bits of the last one fall off
                            repeat (9) msg_bytes.push_back({1'b1, 7'($urandom())});
                            msg_bytes.push_back({1'b0, 7'($urandom())});
                        end else if (r < 13) begin
                            // continuation still set on the tenth byte
                            repeat (10) msg_bytes.push_back({1'b1, 7'($urandom())});
                            msg_bytes.push_back(8'($urandom()));
                        end else begin
                            val = {$urandom(), $urandom()};
                            case ($urandom_range(2))
                                0:       val = 64'($urandom_range(0, 300));
                                1:       val = val >> $urandom_range(0, 63);
                                default: ;
                            endcase
                            push_varint(val, ($urandom_range(7) == 0) ? 2 : 0);
                        end
                    end else if (wire_sel == WIRE_FIXED32) begin
                        repeat (4) msg_bytes.push_back(8'($urandom()));
                    end else if (wire_sel == WIRE_FIXED64) begin
                        repeat (8) msg_bytes.push_back(8'($urandom()));
                    end else if (wire_sel == WIRE_LENGTH) begin
                        if ($urandom_range(9) == 0) begin
                            // length that may run past the message end
                            len = $urandom_range(7, 40);
                            push_varint(64'(len), 0);
                            repeat ($urandom_range(0, 8)) msg_bytes.push_back(8'($urandom()));
                        end else begin
                            len = $urandom_range(0, 6);
                            push_varint(64'(len), ($urandom_range(7) == 0) ? 1 : 0);
                            repeat (len) msg_bytes.push_back(8'($urandom()));
                        end
                    end
                end
                r = $urandom_range(99);
                if (r < 15 && msg_bytes.size() > 1) begin
                    cut = $urandom_range(1, msg_bytes.size() - 1);
                    while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
                end else if (r < 25) begin
                    msg_bytes.delete();
                    repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom()));
                end
                for (int k = 0; k < msg_bytes.size(); k++) begin
                    apply_byte(msg_bytes[k], (k == msg_bytes.size() - 1), 1'b0, NO_TOKEN);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("protobuf_wire_tokenizer regression: pass");
        end else begin
            $display("protobuf_wire_tokenizer regression: fail");
        end
        $finish;
    end

endmodule
